### hdl/page_frame_table_random_replace_defines.svh
// Assertion helpers shared by the page frame table RTL.
`ifndef PAGE_FRAME_TABLE_RANDOM_REPLACE_DEFINES_SVH
`define PAGE_FRAME_TABLE_RANDOM_REPLACE_DEFINES_SVH

// Same-cycle implication.
`define PFTRR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PFTRR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/pftrr_pkg.sv
package pftrr_pkg;

  localparam int FRAMES_DEF     = 16;
  localparam int PAGE_BITS_DEF  = 16;
  localparam int COUNT_BITS_DEF = 32;

  localparam int FIU_W     = 5;
  localparam logic [FIU_W-1:0] FIU_RESET = 5'd16;
  localparam int RND_W     = 16;
  localparam int PAGE_W    = 16;
  localparam int IDX_OUT_W = 4;
  localparam int TOTAL_W   = 32;

  typedef enum logic [1:0] {
    OUT_HIT         = 2'd0,
    OUT_FILL        = 2'd1,
    OUT_EVICT_CLEAN = 2'd2,
    OUT_EVICT_DIRTY = 2'd3
  } outcome_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic vread;
    logic evict;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic hit_now;
    logic free_now;
    logic scan_last;
    logic free_seen;
    logic mod_done;
    logic out_blocked;
  } stat_t;

endpackage

### hdl/pftrr_ram.sv
module pftrr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/pftrr_ctrl.sv
`include "page_frame_table_random_replace_defines.svh"

module pftrr_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  pftrr_pkg::stat_t stat,
  output pftrr_pkg::cmd_t  cmd
);

  typedef enum logic [4:0] {
    IDLE   = 5'b00001,
    SCAN   = 5'b00010,
    VREAD  = 5'b00100,
    EVICT  = 5'b01000,
    FINISH = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = SCAN;
        end
      end
      SCAN: begin
        cmd.scan = 1'b1;
        if (stat.hit_now) begin
          state_next = FINISH;
        end else if (stat.scan_last) begin
          if (stat.free_now || stat.free_seen) begin
            state_next = FINISH;
          end else begin
            state_next = VREAD;
          end
        end
      end
      VREAD: begin
        // victim address is live once the remainder is final
        cmd.vread = 1'b1;
        if (stat.mod_done) begin
          state_next = EVICT;
        end
      end
      EVICT: begin
        cmd.vread  = 1'b1;
        cmd.evict  = 1'b1;
        state_next = FINISH;
      end
      FINISH: begin
        if (!stat.out_blocked) begin
          cmd.commit = 1'b1;
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  assign in_stall = (state != IDLE);

  `PFTRR_ASSERT_NEXT(a_load_enters_scan, clk, rst, cmd.load, state == SCAN, "load did not start scan")
  `PFTRR_ASSERT_NOW(a_evict_after_vread, clk, rst, state == EVICT, $past(state == VREAD), "evict without victim read")

endmodule

### hdl/pftrr_dp.sv
`include "page_frame_table_random_replace_defines.svh"

module pftrr_dp #(
  parameter int FRAMES     = pftrr_pkg::FRAMES_DEF,
  parameter int PAGE_BITS  = pftrr_pkg::PAGE_BITS_DEF,
  parameter int COUNT_BITS = pftrr_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pftrr_pkg::FIU_W-1:0]       frames_in_use,
  input  logic [pftrr_pkg::PAGE_W-1:0]      page_number,
  input  logic                              is_write,
  input  logic [pftrr_pkg::RND_W-1:0]       random_value,
  input  pftrr_pkg::cmd_t                   cmd,
  output pftrr_pkg::stat_t                  stat,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic [1:0]                        outcome,
  output logic [pftrr_pkg::IDX_OUT_W-1:0]   frame_index,
  output logic [pftrr_pkg::PAGE_W-1:0]      evicted_page,
  output logic [pftrr_pkg::TOTAL_W-1:0]     access_total,
  output logic [pftrr_pkg::TOTAL_W-1:0]     fault_total,
  output logic [pftrr_pkg::TOTAL_W-1:0]     disk_write_total
);

  localparam int FIU_W = pftrr_pkg::FIU_W;
  localparam int RND_W = pftrr_pkg::RND_W;
  localparam int FW    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int NMAX  = (FRAMES < 31) ? FRAMES : 31;
  localparam int CW    = (FW > FIU_W) ? FW : FIU_W;
  localparam int MCW   = $clog2(RND_W + 1);

  logic [FIU_W-1:0]      fiu;
  logic [FIU_W-1:0]      n;
  logic [FIU_W-1:0]      n_last;

  logic [PAGE_BITS-1:0]  page_q;
  logic                  wr_q;
  logic [RND_W-1:0]      rnd_sh;
  logic [FIU_W-1:0]      rem;
  logic [FIU_W-1:0]      rem_next;
  logic [FIU_W:0]        rem_shift;
  logic [MCW-1:0]        mod_cnt;

  logic [FW-1:0]         scan_idx;
  logic [FW-1:0]         cmp_idx;
  logic                  cmp_en;
  logic                  hit_q;
  logic                  free_q;
  logic                  dirty_q;
  logic [FW-1:0]         slot_q;
  logic [FW-1:0]         victim;
  logic [PAGE_BITS-1:0]  evicted_q;

  logic [FRAMES-1:0]     frame_valid;
  logic [FRAMES-1:0]     frame_dirty;
  logic [COUNT_BITS-1:0] access_count, fault_count, write_count;
  logic [COUNT_BITS-1:0] access_count_next, fault_count_next, write_count_next;

  logic [PAGE_BITS-1:0]  rdata;
  logic [FW-1:0]         raddr;
  logic                  ram_we;
  pftrr_pkg::outcome_t   outcome_next;

  assign cfg_ready = 1'b1;

  // effective frame count: zero acts as one, clamp at the table size or 31, whichever is smaller
  always_comb begin
    if (fiu == '0) begin
      n = FIU_W'(1);
    end else if (fiu > FIU_W'(NMAX)) begin
      n = FIU_W'(NMAX);
    end else begin
      n = fiu;
    end
  end
  assign n_last = n - FIU_W'(1);
  assign victim = FW'(rem);

  // one restoring remainder step per cycle, MSB first
  assign rem_shift = {rem, rnd_sh[RND_W-1]};
  assign rem_next  = (rem_shift >= {1'b0, n}) ? FIU_W'(rem_shift - {1'b0, n})
                                              : rem_shift[FIU_W-1:0];

  assign raddr  = cmd.vread ? victim : scan_idx;
  assign ram_we = cmd.commit && !hit_q;

  pftrr_ram #(
    .WIDTH (PAGE_BITS),
    .DEPTH (FRAMES)
  ) u_page_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_q),
    .wdata (page_q),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign stat.hit_now     = cmp_en && frame_valid[cmp_idx] && (rdata == page_q);
  assign stat.free_now    = cmp_en && !frame_valid[cmp_idx];
  assign stat.scan_last   = cmp_en && (CW'(cmp_idx) == CW'(n_last));
  assign stat.free_seen   = free_q;
  assign stat.mod_done    = (mod_cnt == MCW'(RND_W));
  assign stat.out_blocked = out_valid && out_stall;

  always_comb begin
    access_count_next = (access_count == '1) ? access_count
                                             : access_count + COUNT_BITS'(1);
    fault_count_next  = fault_count;
    write_count_next  = write_count;
    if (!hit_q) begin
      fault_count_next = (fault_count == '1) ? fault_count
                                             : fault_count + COUNT_BITS'(1);
    end
    if (!hit_q && !free_q && dirty_q) begin
      write_count_next = (write_count == '1) ? write_count
                                             : write_count + COUNT_BITS'(1);
    end
    priority if (hit_q) begin
      outcome_next = pftrr_pkg::OUT_HIT;
    end else if (free_q) begin
      outcome_next = pftrr_pkg::OUT_FILL;
    end else if (dirty_q) begin
      outcome_next = pftrr_pkg::OUT_EVICT_DIRTY;
    end else begin
      outcome_next = pftrr_pkg::OUT_EVICT_CLEAN;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      fiu          <= pftrr_pkg::FIU_RESET;
      frame_valid  <= '0;
      frame_dirty  <= '0;
      access_count <= '0;
      fault_count  <= '0;
      write_count  <= '0;
      out_valid    <= 1'b0;
      cmp_en       <= 1'b0;
      hit_q        <= 1'b0;
      free_q       <= 1'b0;
      mod_cnt      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        fiu <= frames_in_use;
      end
      cmp_en <= cmd.scan;
      if (cmd.load) begin
        hit_q   <= 1'b0;
        free_q  <= 1'b0;
        mod_cnt <= '0;
      end else begin
        if (!stat.mod_done) begin
          mod_cnt <= mod_cnt + MCW'(1);
        end
        if (cmd.scan && stat.hit_now) begin
          hit_q <= 1'b1;
        end
        if (cmd.scan && stat.free_now) begin
          free_q <= 1'b1;
        end
      end
      if (cmd.commit) begin
        access_count <= access_count_next;
        fault_count  <= fault_count_next;
        write_count  <= write_count_next;
        if (hit_q) begin
          if (wr_q) begin
            frame_dirty[slot_q] <= 1'b1;
          end
        end else begin
          frame_valid[slot_q] <= 1'b1;
          frame_dirty[slot_q] <= wr_q;
        end
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      page_q   <= PAGE_BITS'(page_number);
      wr_q     <= is_write;
      rnd_sh   <= random_value;
      rem      <= '0;
      scan_idx <= '0;
    end else begin
      if (!stat.mod_done) begin
        rem    <= rem_next;
        rnd_sh <= {rnd_sh[RND_W-2:0], 1'b0};
      end
      if (cmd.scan && (CW'(scan_idx) < CW'(n_last))) begin
        scan_idx <= scan_idx + FW'(1);
      end
    end
    cmp_idx <= scan_idx;
    // lowest free frame sticks; a hit ends the scan
    if (cmd.scan && (stat.hit_now || (stat.free_now && !free_q))) begin
      slot_q <= cmp_idx;
    end
    if (cmd.evict) begin
      slot_q    <= victim;
      evicted_q <= rdata;
      dirty_q   <= frame_dirty[victim];
    end
    if (cmd.commit) begin
      outcome          <= outcome_next;
      frame_index      <= pftrr_pkg::IDX_OUT_W'(slot_q);
      evicted_page     <= (hit_q || free_q) ? '0 : pftrr_pkg::PAGE_W'(evicted_q);
      access_total     <= pftrr_pkg::TOTAL_W'(access_count_next);
      fault_total      <= pftrr_pkg::TOTAL_W'(fault_count_next);
      disk_write_total <= pftrr_pkg::TOTAL_W'(write_count_next);
    end
  end

  `PFTRR_ASSERT_NOW(a_commit_not_blocked, clk, rst, cmd.commit, !(out_valid && out_stall), "commit over held word")
  `PFTRR_ASSERT_NEXT(a_commit_shows_word, clk, rst, cmd.commit, out_valid, "committed word not shown")
  `PFTRR_ASSERT_NOW(a_victim_in_range, clk, rst, cmd.evict, rem < n, "victim beyond frame count")
  `PFTRR_ASSERT_NOW(a_hit_or_free, clk, rst, 1'b1, !(hit_q && free_q), "hit and free fill together")

endmodule

### hdl/page_frame_table_random_replace.sv
// From accept to result: a hit on frame k ends the tag scan at that frame;
// a fill runs the tag scan to the last frame in use; an eviction waits for
// both that scan and the 16-step remainder, then updates the frame.
// Throughput: one access at a time; the next is accepted once the result is
// registered, while that result may still wait at the output.
// Reset (rst, synchronous): table empty, counters zero, frames_in_use 16.
module page_frame_table_random_replace #(
  parameter int FRAMES     = pftrr_pkg::FRAMES_DEF,
  parameter int PAGE_BITS  = pftrr_pkg::PAGE_BITS_DEF,
  parameter int COUNT_BITS = pftrr_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pftrr_pkg::FIU_W-1:0]     frames_in_use,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [pftrr_pkg::PAGE_W-1:0]    page_number,
  input  logic                            is_write,
  input  logic [pftrr_pkg::RND_W-1:0]     random_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      outcome,
  output logic [pftrr_pkg::IDX_OUT_W-1:0] frame_index,
  output logic [pftrr_pkg::PAGE_W-1:0]    evicted_page,
  output logic [pftrr_pkg::TOTAL_W-1:0]   access_total,
  output logic [pftrr_pkg::TOTAL_W-1:0]   fault_total,
  output logic [pftrr_pkg::TOTAL_W-1:0]   disk_write_total
);

  pftrr_pkg::cmd_t  cmd;
  pftrr_pkg::stat_t stat;

  pftrr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  pftrr_dp #(
    .FRAMES     (FRAMES),
    .PAGE_BITS  (PAGE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .frames_in_use    (frames_in_use),
    .page_number      (page_number),
    .is_write         (is_write),
    .random_value     (random_value),
    .cmd              (cmd),
    .stat             (stat),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .outcome          (outcome),
    .frame_index      (frame_index),
    .evicted_page     (evicted_page),
    .access_total     (access_total),
    .fault_total      (fault_total),
    .disk_write_total (disk_write_total)
  );

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import pftrr_pkg::*;

  localparam int NFRAMES = FRAMES_DEF;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    bit                    is_cfg;
    logic [FIU_W-1:0]      frames;
    logic [PAGE_W-1:0]     page;
    logic                  wr;
    logic [RND_W-1:0]      rnd;
  } trace_item_t;

  typedef struct {
    outcome_t              oc;
    logic [IDX_OUT_W-1:0]  idx;
    logic [PAGE_W-1:0]     evicted;
    logic [TOTAL_W-1:0]    accesses;
    logic [TOTAL_W-1:0]    faults;
    logic [TOTAL_W-1:0]    disk_writes;
  } access_result_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [FIU_W-1:0] frames_in_use = FIU_RESET;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [PAGE_W-1:0] page_number = '0;
  logic is_write = 1'b0;
  logic [RND_W-1:0] random_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] outcome;
  logic [IDX_OUT_W-1:0] frame_index;
  logic [PAGE_W-1:0] evicted_page;
  logic [TOTAL_W-1:0] access_total;
  logic [TOTAL_W-1:0] fault_total;
  logic [TOTAL_W-1:0] disk_write_total;

  page_frame_table_random_replace dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .frames_in_use    (frames_in_use),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .page_number      (page_number),
    .is_write         (is_write),
    .random_value     (random_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .outcome          (outcome),
    .frame_index      (frame_index),
    .evicted_page     (evicted_page),
    .access_total     (access_total),
    .fault_total      (fault_total),
    .disk_write_total (disk_write_total)
  );

  // shadow of the frame table
  logic               tbl_valid [NFRAMES];
  logic [PAGE_W-1:0]  tbl_page  [NFRAMES];
  logic               tbl_dirty [NFRAMES];
  logic [TOTAL_W-1:0] cnt_access;
  logic [TOTAL_W-1:0] cnt_fault;
  logic [TOTAL_W-1:0] cnt_diskwr;
  logic [FIU_W-1:0]   fiu_shadow;

  trace_item_t    access_trace[$];
  access_result_t lookup_replies[$];
  int unsigned    words_sent = 0;
  int unsigned    words_seen = 0;
  bit             failed = 1'b0;
  logic           calm = 1'b0;
  int unsigned    cycles = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [TOTAL_W-1:0] sat_bump(logic [TOTAL_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic void page_lookup(trace_item_t a);
    access_result_t r;
    int n;
    int i;
    int slot;
    bit hit;
    bit have_free;
    n = (fiu_shadow == 0) ? 1 : ((fiu_shadow > NFRAMES) ? NFRAMES : int'(fiu_shadow));
    slot = 0;
    hit = 1'b0;
    have_free = 1'b0;
    r.evicted = '0;
    for (i = 0; i < n; i++) begin
      if (!hit && tbl_valid[i] && tbl_page[i] == a.page) begin
        hit = 1'b1;
        slot = i;
      end
    end
    if (hit) begin
      if (a.wr) tbl_dirty[slot] = 1'b1;
      r.oc = OUT_HIT;
    end else begin
      cnt_fault = sat_bump(cnt_fault);
      for (i = 0; i < n; i++) begin
        if (!have_free && !tbl_valid[i]) begin
          have_free = 1'b1;
          slot = i;
        end
      end
      if (have_free) begin
        r.oc = OUT_FILL;
      end else begin
        slot = int'(a.rnd) % n;
        r.evicted = tbl_page[slot];
        if (tbl_dirty[slot]) begin
          cnt_diskwr = sat_bump(cnt_diskwr);
          r.oc = OUT_EVICT_DIRTY;
        end else begin
          r.oc = OUT_EVICT_CLEAN;
        end
      end
      tbl_valid[slot] = 1'b1;
      tbl_page[slot] = a.page;
      tbl_dirty[slot] = a.wr;
    end
    cnt_access = sat_bump(cnt_access);
    r.idx = slot[IDX_OUT_W-1:0];
    r.accesses = cnt_access;
    r.faults = cnt_fault;
    r.disk_writes = cnt_diskwr;
    lookup_replies.push_back(r);
  endfunction

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, what, want, got);
      failed = 1'b1;
    end
  endfunction

  function automatic void queue_access(logic [PAGE_W-1:0] page, logic wr, logic [RND_W-1:0] rnd);
    trace_item_t t;
    t.is_cfg = 1'b0;
    t.frames = '0;
    t.page = page;
    t.wr = wr;
    t.rnd = rnd;
    access_trace.push_back(t);
  endfunction

  function automatic void queue_frames(logic [FIU_W-1:0] v);
    trace_item_t t;
    t.is_cfg = 1'b1;
    t.frames = v;
    t.page = '0;
    t.wr = 1'b0;
    t.rnd = '0;
    access_trace.push_back(t);
  endfunction

  // driver: presents trace words, shadows the table on each accepted word
  int  in_gap = 0;
  int  in_mode_left = 0;
  bit  in_idle_on = 1'b1;

  always @(posedge clk) begin
    trace_item_t cur;
    logic nv;
    logic ncv;
    int i;
    if (rst) begin
      in_valid <= 1'b0;
      cfg_valid <= 1'b0;
      for (i = 0; i < NFRAMES; i++) begin
        tbl_valid[i] = 1'b0;
        tbl_page[i] = '0;
        tbl_dirty[i] = 1'b0;
      end
      cnt_access = '0;
      cnt_fault = '0;
      cnt_diskwr = '0;
      fiu_shadow = FIU_RESET;
    end else begin
      nv = in_valid;
      ncv = cfg_valid;
      if (in_valid && !in_stall) begin
        page_lookup(access_trace[0]);
        void'(access_trace.pop_front());
        words_sent++;
        nv = 1'b0;
        if (in_mode_left > 0) begin
          in_mode_left--;
        end else begin
          in_mode_left = $urandom_range(20, 120);
          in_idle_on = ($urandom_range(0, 2) != 0);
        end
      end
      if (cfg_valid && cfg_ready) begin
        fiu_shadow = access_trace[0].frames;
        void'(access_trace.pop_front());
        ncv = 1'b0;
      end
      if (!nv && !ncv) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (access_trace.size() != 0) begin
          cur = access_trace[0];
          if (cur.is_cfg) begin
            // only touch the register once every reply is back
            if (words_sent == words_seen) begin
              ncv = 1'b1;
              frames_in_use <= cur.frames;
            end
          end else if (in_idle_on && !calm && $urandom_range(0, 4) == 0) begin
            in_gap = $urandom_range(1, 13) - 1;
          end else begin
            nv = 1'b1;
            page_number <= cur.page;
            is_write <= cur.wr;
            random_value <= cur.rnd;
          end
        end
      end
      in_valid <= nv;
      cfg_valid <= ncv;
      calm <= (access_trace.size() < 120);
    end
  end

  // monitor: retires replies against the shadow's predictions
  int  st_gap = 0;
  int  st_mode_left = 0;
  bit  st_idle_on = 1'b1;

  always @(posedge clk) begin
    access_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        words_seen <= words_seen + 1;
        if (lookup_replies.size() == 0) begin
          $display("%0t: reply with nothing outstanding, outcome %0d frame %0d", $time,
                   outcome, frame_index);
          failed = 1'b1;
        end else begin
          want = lookup_replies.pop_front();
          check_field("outcome", want.oc, outcome);
          check_field("frame_index", want.idx, frame_index);
          check_field("evicted_page", want.evicted, evicted_page);
          check_field("access_total", want.accesses, access_total);
          check_field("fault_total", want.faults, fault_total);
          check_field("disk_write_total", want.disk_writes, disk_write_total);
        end
      end
      if (st_mode_left > 0) begin
        st_mode_left--;
      end else begin
        st_mode_left = $urandom_range(50, 400);
        st_idle_on = ($urandom_range(0, 2) != 0);
      end
      if (st_gap > 0) begin
        st_gap--;
        out_stall <= 1'b1;
      end else if (st_idle_on && !calm && $urandom_range(0, 7) == 0) begin
        st_gap = $urandom_range(1, 13) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic [FIU_W-1:0] cfg_plan [12];
    int p;
    int k;
    int n;
    int ws;
    logic [PAGE_W-1:0] base;

    // directed: fills, hits on both page extremes, then evictions
    queue_access(16'h0000, 1'b0, 16'h0000);
    queue_access(16'hffff, 1'b1, 16'h0000);
    queue_access(16'h0000, 1'b1, 16'hffff);
    queue_access(16'hffff, 1'b0, 16'h0000);
    for (k = 1; k <= 14; k++) queue_access(16'(k * 16'h1111), k[0], 16'(k));
    queue_access(16'h1234, 1'b0, 16'hffff);   // victim is the top frame
    queue_access(16'h4321, 1'b1, 16'h0000);   // dirty victim in frame 0
    queue_access(16'h4321, 1'b0, 16'h5555);
    queue_access(16'h0000, 1'b0, 16'h0011);   // dirty page ffff goes out

    // zero acts as one, above table size clamps; shrinking hides frames
    cfg_plan = '{5'd0, 5'd1, 5'd16, 5'd31, 5'd17, 5'd2, 5'd8, 5'd15, 5'd3, 5'd0, 5'd0, 5'd16};
    cfg_plan[9] = 5'($urandom_range(0, 31));
    cfg_plan[10] = 5'($urandom_range(0, 31));
    for (p = 0; p < 12; p++) begin
      queue_frames(cfg_plan[p]);
      n = (cfg_plan[p] == 0) ? 1 : ((cfg_plan[p] > NFRAMES) ? NFRAMES : int'(cfg_plan[p]));
      ws = $urandom_range(n / 2 + 1, 2 * n + 3);
      base = 16'($urandom);
      for (k = 0; k < 148; k++) begin
        if ($urandom_range(0, 9) == 0)
          queue_access(16'($urandom), 1'($urandom), 16'($urandom));
        else
          queue_access(base + 16'($urandom_range(0, ws - 1)), 1'($urandom), 16'($urandom));
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (access_trace.size() != 0 || words_sent != words_seen) @(posedge clk);
    repeat (30) @(posedge clk);
    if (lookup_replies.size() != 0) begin
      $display("%0t: %0d replies never arrived", $time, lookup_replies.size());
      failed = 1'b1;
    end
    if (!failed) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
